// ===== hw/rtl/olq_pkg.sv =====
// ---------------------------------------------------------------------------
// olq_pkg: shared types and constants for the outline to quadratic converter
// Coordinate widths, vertex kind codes and the structs passed between stages.
// ---------------------------------------------------------------------------
package olq_pkg;

   localparam int COORD_BITS      = 16;
   localparam int SCALE_FRAC_BITS = 16;
   localparam int EXTRA_FRAC      = 3;
   localparam int OUT_BITS        = COORD_BITS + SCALE_FRAC_BITS + EXTRA_FRAC;

   localparam int REQ_DATA_BITS   = 6 * COORD_BITS;
   localparam int RSP_FIELD_BITS  = 6 * OUT_BITS;
   localparam int RSP_DATA_BITS   = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS    = RSP_DATA_BITS - RSP_FIELD_BITS;

   localparam logic [SCALE_FRAC_BITS-1:0] UNIT_SCALE_RESET = SCALE_FRAC_BITS'(32);

   localparam logic [1:0] KIND_MOVE  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_QUAD  = 2'd2;
   localparam logic [1:0] KIND_CUBIC = 2'd3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [OUT_BITS-1:0]   point_type;

   typedef struct packed {
      logic       starts_glyph;
      logic [1:0] vertex_kind;
      coord_type  end_x;
      coord_type  end_y;
      coord_type  ctrl1_x;
      coord_type  ctrl1_y;
      coord_type  ctrl2_x;
      coord_type  ctrl2_y;
   } vertex_type;

   typedef struct packed {
      logic       starts_glyph;
      logic [1:0] vertex_kind;
      point_type  end_x;
      point_type  end_y;
      point_type  ctrl1_x;
      point_type  ctrl1_y;
      point_type  ctrl2_x;
      point_type  ctrl2_y;
   } scaled_type;

   typedef struct packed {
      point_type start_px;
      point_type start_py;
      point_type mid_px;
      point_type mid_py;
      point_type stop_px;
      point_type stop_py;
      logic      last_of_run;
   } curve_type;

   typedef struct packed {
      logic busy;
      logic kind_cubic;
      logic second_half;
   } curve_status_type;

endpackage

// ===== hw/rtl/olq_scale.sv =====
// ---------------------------------------------------------------------------
// olq_scale: input register and em scaling stage
// Registers the vertex, multiplies all six coordinates by the em scale.
// ---------------------------------------------------------------------------
module olq_scale (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  olq_pkg::vertex_type                   in_vertex,
   input  logic [olq_pkg::SCALE_FRAC_BITS-1:0]   unit_scale,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output olq_pkg::scaled_type                   out_item
);
   import olq_pkg::*;

   localparam int PROD_BITS = COORD_BITS + SCALE_FRAC_BITS + 1;

   logic       raw_valid_ff;
   vertex_type raw_ff;
   logic       scl_valid_ff;
   scaled_type scl_ff;
   scaled_type scl_in;
   logic       raw_take;
   logic       scl_take;

   // c * scale * 8; the product magnitude stays below 2^31
   function automatic point_type scale_coord(input coord_type c,
                                             input logic [SCALE_FRAC_BITS-1:0] s);
      logic signed [PROD_BITS-1:0] prod;
      prod = PROD_BITS'(c) * $signed({1'b0, s});
      return {prod[OUT_BITS-EXTRA_FRAC-1:0], {EXTRA_FRAC{1'b0}}};
   endfunction

   assign scl_take = !scl_valid_ff || out_ready;
   assign raw_take = !raw_valid_ff || scl_take;
   assign in_ready = raw_take;

   always_comb begin
      scl_in.starts_glyph = raw_ff.starts_glyph;
      scl_in.vertex_kind  = raw_ff.vertex_kind;
      scl_in.end_x        = scale_coord(raw_ff.end_x,   unit_scale);
      scl_in.end_y        = scale_coord(raw_ff.end_y,   unit_scale);
      scl_in.ctrl1_x      = scale_coord(raw_ff.ctrl1_x, unit_scale);
      scl_in.ctrl1_y      = scale_coord(raw_ff.ctrl1_y, unit_scale);
      scl_in.ctrl2_x      = scale_coord(raw_ff.ctrl2_x, unit_scale);
      scl_in.ctrl2_y      = scale_coord(raw_ff.ctrl2_y, unit_scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_valid_ff <= 1'b0;
         scl_valid_ff <= 1'b0;
      end else begin
         if (raw_take) begin
            raw_valid_ff <= in_valid;
         end
         if (scl_take) begin
            scl_valid_ff <= raw_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (raw_take && in_valid) begin
         raw_ff <= in_vertex;
      end
      if (scl_take && raw_valid_ff) begin
         scl_ff <= scl_in;
      end
   end

   assign out_valid = scl_valid_ff;
   assign out_item  = scl_ff;

endmodule

// ===== hw/rtl/olq_curve.sv =====
// ---------------------------------------------------------------------------
// olq_curve: pen tracking and quadratic curve formation
// Builds one or two quadratic beats from a scaled line, quadratic or cubic vertex and the pen point;
// a move vertex gives no beat and only sets the pen point.
module olq_curve (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  olq_pkg::scaled_type         in_item,
   input  logic                        out_free,
   output logic                        out_load,
   output olq_pkg::curve_type          out_beat,
   output olq_pkg::curve_status_type   status
);
   import olq_pkg::*;

   localparam int SUM_BITS = OUT_BITS + 3;

   point_type pen_x_ff;
   point_type pen_y_ff;
   logic      phase_ff;
   point_type p0x;
   point_type p0y;
   point_type cmx;
   point_type cmy;
   logic      is_move;
   logic      is_cubic;
   logic      release_item;

   // all values are multiples of 8, so these shifts are exact
   function automatic point_type half_sum(input point_type a, input point_type b);
      logic signed [OUT_BITS:0] s;
      s = (OUT_BITS+1)'(a) + (OUT_BITS+1)'(b);
      return s[OUT_BITS:1];
   endfunction

   function automatic point_type cubic_mid(input point_type p0, input point_type c1,
                                           input point_type c2, input point_type p3);
      logic signed [SUM_BITS-1:0] a;
      logic signed [SUM_BITS-1:0] b;
      logic signed [SUM_BITS-1:0] s;
      a = SUM_BITS'(c1) + SUM_BITS'(c2);
      b = SUM_BITS'(p0) + SUM_BITS'(p3);
      s = b + (a <<< 1) + a;
      return s[SUM_BITS-1:3];
   endfunction

   assign p0x      = in_item.starts_glyph ? '0 : pen_x_ff;
   assign p0y      = in_item.starts_glyph ? '0 : pen_y_ff;
   assign is_move  = (in_item.vertex_kind == KIND_MOVE);
   assign is_cubic = (in_item.vertex_kind == KIND_CUBIC);
   assign cmx      = cubic_mid(p0x, in_item.ctrl1_x, in_item.ctrl2_x, in_item.end_x);
   assign cmy      = cubic_mid(p0y, in_item.ctrl1_y, in_item.ctrl2_y, in_item.end_y);

   assign out_load     = in_valid && !is_move && out_free;
   assign release_item = in_valid && (is_move || (out_free && (!is_cubic || phase_ff)));
   assign in_ready     = release_item;

   always_comb begin
      out_beat.start_px    = p0x;
      out_beat.start_py    = p0y;
      out_beat.mid_px      = in_item.ctrl1_x;
      out_beat.mid_py      = in_item.ctrl1_y;
      out_beat.stop_px     = in_item.end_x;
      out_beat.stop_py     = in_item.end_y;
      out_beat.last_of_run = 1'b1;
      case (in_item.vertex_kind)
         KIND_LINE: begin
            out_beat.mid_px = half_sum(p0x, in_item.end_x);
            out_beat.mid_py = half_sum(p0y, in_item.end_y);
         end
         KIND_CUBIC: begin
            if (!phase_ff) begin
               out_beat.mid_px      = half_sum(p0x, in_item.ctrl1_x);
               out_beat.mid_py      = half_sum(p0y, in_item.ctrl1_y);
               out_beat.stop_px     = cmx;
               out_beat.stop_py     = cmy;
               out_beat.last_of_run = 1'b0;
            end else begin
               out_beat.start_px = cmx;
               out_beat.start_py = cmy;
               out_beat.mid_px   = half_sum(in_item.ctrl2_x, in_item.end_x);
               out_beat.mid_py   = half_sum(in_item.ctrl2_y, in_item.end_y);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         if (out_load && is_cubic) begin
            phase_ff <= !phase_ff;
         end
         if (release_item) begin
            pen_x_ff <= in_item.end_x;
            pen_y_ff <= in_item.end_y;
         end
      end
   end

   assign status.busy        = in_valid;
   assign status.kind_cubic  = is_cubic;
   assign status.second_half = phase_ff;

endmodule

// ===== hw/rtl/outline_to_quadratic_curves.sv =====
// ---------------------------------------------------------------------------
// outline_to_quadratic_curves: glyph outline vertices to quadratic curves
// Scales vertices to em units and emits quadratic curves, splitting cubics.
// ---------------------------------------------------------------------------
// Path: a vertex beat passes the input, scale and result registers in turn.
// Throughput: one vertex a cycle for move, line and quadratic while rsp_tready holds; a cubic
//   holds the curve stage until it has given two beats on the one rsp port.
// Reset: synchronous; pen cleared to origin, em scale back to 32, pipe empty.
// ---------------------------------------------------------------------------
module outline_to_quadratic_curves (
   input  logic                                  clock,
   input  logic                                  reset,
   // vertex beats
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y (16 bits each)
   input  logic [olq_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // starts_glyph, vertex_kind[1:0]
   input  logic [2:0]                            req_tuser,
   // curve beats
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // start_px, start_py, mid_px, mid_py, stop_px, stop_py (35 bits each),
   // zero pad
   output logic [olq_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // last_of_run
   output logic                                  rsp_tlast,
   // em scale register
   input  logic                                  csr_wr_en,
   input  logic [olq_pkg::SCALE_FRAC_BITS-1:0]   csr_wr_data
);
   import olq_pkg::*;

   logic [SCALE_FRAC_BITS-1:0] unit_scale_ff;
   vertex_type                 req_vertex;
   logic                       scl_valid;
   logic                       scl_ready;
   scaled_type                 scl_item;
   logic                       out_free;
   logic                       out_load;
   curve_type                  out_beat;
   curve_status_type           cur_status;
   logic                       rsp_valid_ff;
   curve_type                  beat_ff;

   // unpack the vertex beat: kind and glyph start ride on tuser
   assign req_vertex.starts_glyph = req_tuser[0];
   assign req_vertex.vertex_kind  = req_tuser[2:1];
   assign req_vertex.end_x        = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign req_vertex.end_y        = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign req_vertex.ctrl1_x      = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign req_vertex.ctrl1_y      = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign req_vertex.ctrl2_x      = req_tdata[4*COORD_BITS +: COORD_BITS];
   assign req_vertex.ctrl2_y      = req_tdata[5*COORD_BITS +: COORD_BITS];

   // em scale: the user must write it only while the pipe is empty; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_scale_ff <= UNIT_SCALE_RESET;
      end else if (csr_wr_en) begin
         unit_scale_ff <= csr_wr_data;
      end
   end

   olq_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_vertex  (req_vertex),
      .unit_scale (unit_scale_ff),
      .out_valid  (scl_valid),
      .out_ready  (scl_ready),
      .out_item   (scl_item)
   );

   olq_curve u_curve (
      .clock    (clock),
      .reset    (reset),
      .in_valid (scl_valid),
      .in_ready (scl_ready),
      .in_item  (scl_item),
      .out_free (out_free),
      .out_load (out_load),
      .out_beat (out_beat),
      .status   (cur_status)
   );

   // result register: takes a new beat whenever the held one is gone
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= out_load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         beat_ff <= out_beat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = beat_ff.last_of_run;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}},
                        beat_ff.stop_py, beat_ff.stop_px,
                        beat_ff.mid_py,  beat_ff.mid_px,
                        beat_ff.start_py, beat_ff.start_px};

   // second half of a cubic only while that cubic sits in the curve stage
   a_half_in_cubic: assert property (@(posedge clock) disable iff (reset)
      cur_status.second_half |-> cur_status.busy && cur_status.kind_cubic)
      else $error("second-half flag set without a cubic in the curve stage");

   // a non-final beat leaves the cubic waiting for its second beat
   a_first_then_second: assert property (@(posedge clock) disable iff (reset)
      out_load && !out_beat.last_of_run |=> cur_status.second_half)
      else $error("first cubic beat not followed by second-half state");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat valid straight after reset");

endmodule
